/* src/mpw_pkg.sv */
package mpw_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_WINDOW_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int HEIGHT_LIMIT = 1024;
  localparam int ROW_BITS     = 10;
  localparam int COL_OUT_BITS = 10;
  localparam int IMG_BITS     = 11;
  localparam int WIN_BITS     = 4;
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE_X      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE_Y      = 3'd5;

  // Register values after reset.
  localparam logic [IMG_BITS-1:0] IMAGE_WIDTH_RST   = 11'd32;
  localparam logic [IMG_BITS-1:0] IMAGE_HEIGHT_RST  = 11'd32;
  localparam logic [WIN_BITS-1:0] WINDOW_WIDTH_RST  = 4'd2;
  localparam logic [WIN_BITS-1:0] WINDOW_HEIGHT_RST = 4'd2;
  localparam logic [WIN_BITS-1:0] STRIDE_X_RST      = 4'd2;
  localparam logic [WIN_BITS-1:0] STRIDE_Y_RST      = 4'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_write;
    logic accept;
    logic mem_rd;
    logic mem_wr;
    logic emit;
    logic step;
    logic advance;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic win_ok;
    logic win_emit;
    logic iter_last;
  } stat_t;

endpackage

/* src/max_pool_2d_window_core.sv */
// Channel  Handshake            Payload
// in       in_valid/in_ready    in_sample, in_start_of_matrix
// out      out_valid/out_ready  out_pooled_value, out_col, out_row, out_last_of_matrix
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each sample is accepted first. Then, for every pooling window it falls into,
// the walk reads the store and then writes the update, and it checks every other
// candidate that it visits, a window clipped at the matrix edge or one that misses the
// sample, without touching the store. A new sample is taken only after the walk
// for the last one has ended. The single-port running-maximum store is why the
// read and the update of a window are separate steps.
// Reset is synchronous; it restores the register defaults and the position,
// and the store is not cleared. A pending result stays in the output register
// while the next sample is taken; the walk stalls only when a new result is due.
module max_pool_2d_window_core #(
  parameter int MAX_WIDTH   = mpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW  = mpw_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mpw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  logic                              in_start_of_matrix,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_pooled_value,
  output logic [mpw_pkg::COL_OUT_BITS-1:0]  out_col,
  output logic [mpw_pkg::ROW_BITS-1:0]      out_row,
  output logic                              out_last_of_matrix,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mpw_pkg::IMG_BITS-1:0]      cfg_data
);

  mpw_pkg::cmd_t  cmd;
  mpw_pkg::stat_t st;

  mpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mpw_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_sample          (in_sample),
    .in_start_of_matrix (in_start_of_matrix),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_pooled_value   (out_pooled_value),
    .out_col            (out_col),
    .out_row            (out_row),
    .out_last_of_matrix (out_last_of_matrix)
  );

endmodule

/* src/mpw_ctrl.sv */
module mpw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  mpw_pkg::stat_t st,
  output mpw_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_blocked;

  assign out_blocked = out_valid_r && !out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        if (st.win_ok) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = ST_WRITE;
        end else if (st.iter_last) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_WRITE: begin
        // A finished window waits here while the previous result is still held.
        if (!(st.win_emit && out_blocked)) begin
          cmd.mem_wr = 1'b1;
          cmd.emit   = st.win_emit;
          if (st.iter_last) begin
            cmd.advance = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cmd.cfg_write = cfg_valid && cfg_ready;
  end

  assign out_valid_nxt = out_blocked || cmd.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_emit_not_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_blocked)
    else $error("result emitted while previous result still pending");
  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_rd |=> (state_r == ST_WRITE) && !cmd.accept)
    else $error("memory read not followed by its update");
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("output valid rose without an emit");
  a_cfg_excludes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !cmd.cfg_write)
    else $error("configuration write and input transaction in the same cycle");
`endif

endmodule

/* src/mpw_datapath.sv */
module mpw_datapath #(
  parameter int MAX_WIDTH   = mpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW  = mpw_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mpw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mpw_pkg::cmd_t                         cmd,
  output mpw_pkg::stat_t                        st,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  in_start_of_matrix,
  input  logic [mpw_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [mpw_pkg::IMG_BITS-1:0]          cfg_data,
  output logic signed [SAMPLE_BITS-1:0]         out_pooled_value,
  output logic [mpw_pkg::COL_OUT_BITS-1:0]      out_col,
  output logic [mpw_pkg::ROW_BITS-1:0]          out_row,
  output logic                                  out_last_of_matrix
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CW1   = $clog2(MAX_WIDTH + 1);
  localparam int XW    = CW1 + 2;
  localparam int SW    = $clog2(MAX_WINDOW);
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = mpw_pkg::ROW_BITS;
  localparam int RXW   = mpw_pkg::IMG_BITS + 1;
  localparam int IW    = mpw_pkg::IMG_BITS;
  localparam int WB    = mpw_pkg::WIN_BITS;
  localparam int OCW   = mpw_pkg::COL_OUT_BITS;

  // Configuration registers.
  logic [IW-1:0] image_width_r, image_height_r;
  logic [WB-1:0] window_width_r, window_height_r, stride_x_r, stride_y_r;

  // Effective (clamped) settings.
  logic [CW1-1:0] w_eff;
  logic [IW-1:0]  h_eff;
  logic [WB-1:0]  ww, wh, sx, sy;

  always_comb begin
    if (image_width_r == '0)                    w_eff = CW1'(1);
    else if (int'(image_width_r) > MAX_WIDTH)   w_eff = CW1'(MAX_WIDTH);
    else                                        w_eff = CW1'(image_width_r);
    if (image_height_r == '0)                   h_eff = IW'(1);
    else if (int'(image_height_r) > mpw_pkg::HEIGHT_LIMIT)
                                                h_eff = IW'(mpw_pkg::HEIGHT_LIMIT);
    else                                        h_eff = image_height_r;
    if (window_width_r == '0)                   ww = WB'(1);
    else if (int'(window_width_r) > MAX_WINDOW) ww = WB'(MAX_WINDOW);
    else                                        ww = window_width_r;
    if (window_height_r == '0)                  wh = WB'(1);
    else if (int'(window_height_r) > MAX_WINDOW) wh = WB'(MAX_WINDOW);
    else                                        wh = window_height_r;
    sx = (stride_x_r == '0) ? WB'(1) : stride_x_r;
    sy = (stride_y_r == '0) ? WB'(1) : stride_y_r;
  end

  // Position of the current sample, with its phase inside the stride and
  // the highest window index that can contain it.
  logic [CW-1:0] col_r, wch_r;
  logic [RW-1:0] row_r, wrh_r;
  logic [WB-1:0] phc_r, phr_r;
  logic [SW-1:0] slot_hi_r;

  // Window walk for the current sample.
  logic [WB-1:0] dc_r, dr_r;
  logic [CW-1:0] wc_r;
  logic [RW-1:0] wr_r;
  logic [SW-1:0] slot_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  // Position as seen by an accepted sample after the start flag and wraps.
  logic          col_zero, row_zero;
  logic [CW-1:0] col_a, wch_a;
  logic [RW-1:0] row_a, wrh_a;
  logic [WB-1:0] phc_a, phr_a;
  logic [SW-1:0] slot_a;

  always_comb begin
    col_zero = in_start_of_matrix || (CW1'(col_r) >= w_eff);
    row_zero = in_start_of_matrix || (IW'(row_r) >= h_eff);
    col_a    = col_zero ? '0 : col_r;
    wch_a    = col_zero ? '0 : wch_r;
    phc_a    = col_zero ? '0 : phc_r;
    row_a    = row_zero ? '0 : row_r;
    wrh_a    = row_zero ? '0 : wrh_r;
    phr_a    = row_zero ? '0 : phr_r;
    slot_a   = row_zero ? '0 : slot_hi_r;
  end

  // Window tests. wr*sy equals row - dr and wc*sx equals col - dc.
  logic [RXW-1:0] r_base;
  logic [XW-1:0]  c_base;
  logic           row_fit, col_fit, row_last, col_last;
  logic           top_left, bottom_right;
  logic           inner_more, outer_more;

  always_comb begin
    r_base       = RXW'(row_r) - RXW'(dr_r);
    c_base       = XW'(col_r) - XW'(dc_r);
    row_fit      = (r_base + RXW'(wh)) <= RXW'(h_eff);
    col_fit      = (c_base + XW'(ww)) <= XW'(w_eff);
    row_last     = (r_base + RXW'(sy) + RXW'(wh)) > RXW'(h_eff);
    col_last     = (c_base + XW'(sx) + XW'(ww)) > XW'(w_eff);
    top_left     = (dr_r == '0) && (dc_r == '0);
    bottom_right = (dr_r == wh - WB'(1)) && (dc_r == ww - WB'(1));
    inner_more   = (({1'b0, dc_r} + {1'b0, sx}) < {1'b0, ww}) && (wc_r != '0);
    outer_more   = (({1'b0, dr_r} + {1'b0, sy}) < {1'b0, wh}) && (wr_r != '0) &&
                   (phc_r < ww);
    st.win_ok    = (dr_r < wh) && (dc_r < ww) && row_fit && col_fit;
    st.win_emit  = st.win_ok && bottom_right;
    st.iter_last = !inner_more && !outer_more;
  end

  // Configuration and position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= mpw_pkg::IMAGE_WIDTH_RST;
      image_height_r  <= mpw_pkg::IMAGE_HEIGHT_RST;
      window_width_r  <= mpw_pkg::WINDOW_WIDTH_RST;
      window_height_r <= mpw_pkg::WINDOW_HEIGHT_RST;
      stride_x_r      <= mpw_pkg::STRIDE_X_RST;
      stride_y_r      <= mpw_pkg::STRIDE_Y_RST;
      col_r           <= '0;
      wch_r           <= '0;
      phc_r           <= '0;
      row_r           <= '0;
      wrh_r           <= '0;
      phr_r           <= '0;
      slot_hi_r       <= '0;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        mpw_pkg::CFG_IMAGE_WIDTH:   image_width_r   <= cfg_data;
        mpw_pkg::CFG_IMAGE_HEIGHT:  image_height_r  <= cfg_data;
        mpw_pkg::CFG_WINDOW_WIDTH:  window_width_r  <= cfg_data[WB-1:0];
        mpw_pkg::CFG_WINDOW_HEIGHT: window_height_r <= cfg_data[WB-1:0];
        mpw_pkg::CFG_STRIDE_X:      stride_x_r      <= cfg_data[WB-1:0];
        mpw_pkg::CFG_STRIDE_Y:      stride_y_r      <= cfg_data[WB-1:0];
        default: ;
      endcase
      // Any write to a defined register restarts the matrix position.
      if (cfg_index <= mpw_pkg::CFG_STRIDE_Y) begin
        col_r     <= '0;
        wch_r     <= '0;
        phc_r     <= '0;
        row_r     <= '0;
        wrh_r     <= '0;
        phr_r     <= '0;
        slot_hi_r <= '0;
      end
    end else if (cmd.accept) begin
      col_r     <= col_a;
      wch_r     <= wch_a;
      phc_r     <= phc_a;
      row_r     <= row_a;
      wrh_r     <= wrh_a;
      phr_r     <= phr_a;
      slot_hi_r <= slot_a;
    end else if (cmd.advance) begin
      if ((CW1'(col_r) + CW1'(1)) >= w_eff) begin
        col_r <= '0;
        wch_r <= '0;
        phc_r <= '0;
        if ((IW'(row_r) + IW'(1)) >= h_eff) begin
          row_r     <= '0;
          wrh_r     <= '0;
          phr_r     <= '0;
          slot_hi_r <= '0;
        end else begin
          row_r <= row_r + RW'(1);
          if (phr_r + WB'(1) == sy) begin
            phr_r     <= '0;
            wrh_r     <= wrh_r + RW'(1);
            slot_hi_r <= (slot_hi_r == SW'(MAX_WINDOW - 1)) ? '0 : slot_hi_r + SW'(1);
          end else begin
            phr_r <= phr_r + WB'(1);
          end
        end
      end else begin
        col_r <= col_r + CW'(1);
        if (phc_r + WB'(1) == sx) begin
          phc_r <= '0;
          wch_r <= wch_r + CW'(1);
        end else begin
          phc_r <= phc_r + WB'(1);
        end
      end
    end
  end

  // Walk over the windows that contain the sample: columns inside, rows outside.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      dc_r     <= phc_a;
      wc_r     <= wch_a;
      dr_r     <= phr_a;
      wr_r     <= wrh_a;
      slot_r   <= slot_a;
    end else if (cmd.step) begin
      if (inner_more) begin
        dc_r <= dc_r + sx;
        wc_r <= wc_r - CW'(1);
      end else begin
        dr_r   <= dr_r + sy;
        wr_r   <= wr_r - RW'(1);
        slot_r <= (slot_r == '0) ? SW'(MAX_WINDOW - 1) : slot_r - SW'(1);
        dc_r   <= phc_r;
        wc_r   <= wch_r;
      end
    end
  end

  // Running maxima of the open windows.
  logic signed [SAMPLE_BITS-1:0] max_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SAMPLE_BITS-1:0] new_max;
  logic [AW-1:0]                 addr;

  assign addr    = AW'(slot_r) * AW'(MAX_WIDTH) + AW'(wc_r);
  assign new_max = (top_left || (sample_r > rd_data_r)) ? sample_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data_r <= max_mem[addr];
    end
    if (cmd.mem_wr) begin
      max_mem[addr] <= new_max;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pooled_value   <= new_max;
      out_col            <= OCW'(wc_r);
      out_row            <= wr_r;
      out_last_of_matrix <= col_last && row_last;
    end
  end

endmodule
